[design/scm_pkg.sv]
// shared types and codes for the sorted counted multiset
`default_nettype none
package scm_pkg;

    // command codes carried in the input tuser
    localparam logic [1:0] CMD_ADD    = 2'd0;
    localparam logic [1:0] CMD_REMOVE = 2'd1;
    localparam logic [1:0] CMD_DUMP   = 2'd2;

    // result status codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_NOTFOUND = 3'd1;
    localparam logic [2:0] ST_FULL     = 3'd2;
    localparam logic [2:0] ST_EMPTY    = 3'd3;
    localparam logic [2:0] ST_SAT      = 3'd4;

    localparam int          KEY_W   = 16;
    localparam int          CNT_W   = 16;
    localparam logic [15:0] CNT_MAX = 16'hFFFF;

    // one table entry as held in the ram
    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [CNT_W-1:0] count;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    // one result item from the sequencer
    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [CNT_W-1:0] count;
        logic [2:0]       status;
        logic             last;
    } res_t;

endpackage
`default_nettype wire

[design/scm_ram.sv]
// generic single-write, single-read ram with registered read data
`default_nettype none
module scm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port and registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

[design/scm_ctrl.sv]
// sequencer: linear search with a less-than and an equality key compare, entry shifting, dump walk
`default_nettype none
module scm_ctrl #(
    parameter int DEPTH = 32
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    // input item
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic [1:0]                  in_cmd,
    input  wire logic [scm_pkg::KEY_W-1:0]   in_key,
    // table ram
    output logic                             ram_we,
    output logic [$clog2(DEPTH)-1:0]         ram_waddr,
    output scm_pkg::entry_t                  ram_wdata,
    output logic [$clog2(DEPTH)-1:0]         ram_raddr,
    input  scm_pkg::entry_t                  ram_rdata,
    // result item
    output logic                             res_valid,
    input  wire logic                        res_ready,
    output scm_pkg::res_t                    res
);
    import scm_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] ONE   = CW'(1);
    localparam logic [CW-1:0] TWO   = CW'(2);
    localparam logic [CW-1:0] FULLN = CW'(DEPTH);

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_SEARCH = 8'b0000_0010,
        S_DECIDE = 8'b0000_0100,
        S_SHUP   = 8'b0000_1000,
        S_INSERT = 8'b0001_0000,
        S_SHDN   = 8'b0010_0000,
        S_RESP   = 8'b0100_0000,
        S_DUMP   = 8'b1000_0000
    } state_t;

    state_t            state_reg, state_next;
    logic [1:0]        cmd_reg, cmd_next;
    logic [KEY_W-1:0]  key_reg, key_next;
    logic [CW-1:0]     idx_reg, idx_next;
    logic [CW-1:0]     pos_reg, pos_next;
    logic              found_reg, found_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [CW-1:0]     total_reg, total_next;
    res_t              res_reg, res_next;
    logic [CW-1:0]     raddr_full;
    logic              key_less;
    logic              dump_last;

    // the key less-than compare for the search and the last-entry test for the dump
    assign key_less  = ram_rdata.key < key_reg;
    assign dump_last = (idx_reg + ONE) == total_reg;

    assign in_ready  = (state_reg == S_IDLE);
    assign ram_raddr = raddr_full[AW-1:0];

    // next state and datapath control
    always_comb begin
        state_next = state_reg;
        cmd_next   = cmd_reg;
        key_next   = key_reg;
        idx_next   = idx_reg;
        pos_next   = pos_reg;
        found_next = found_reg;
        cnt_next   = cnt_reg;
        total_next = total_reg;
        res_next   = res_reg;
        raddr_full = idx_reg;
        ram_we     = 1'b0;
        ram_waddr  = idx_reg[AW-1:0];
        ram_wdata  = ram_rdata;
        res_valid  = 1'b0;
        res        = res_reg;

        unique case (state_reg)
            S_IDLE: begin
                raddr_full = '0;
                if (in_valid) begin
                    cmd_next = in_cmd;
                    key_next = in_key;
                    idx_next = '0;
                    case (in_cmd)
                        CMD_ADD, CMD_REMOVE: begin
                            if (total_reg == '0) begin
                                pos_next   = '0;
                                found_next = 1'b0;
                                state_next = S_DECIDE;
                            end else begin
                                state_next = S_SEARCH;
                            end
                        end
                        CMD_DUMP: begin
                            if (total_reg == '0) begin
                                res_next   = '{key: '0, count: '0, status: ST_EMPTY,
                                               last: 1'b1};
                                state_next = S_RESP;
                            end else begin
                                state_next = S_DUMP;
                            end
                        end
                        default: ;
                    endcase
                end
            end

            // one entry compared per cycle
            S_SEARCH: begin
                if (key_less) begin
                    if ((idx_reg + ONE) == total_reg) begin
                        pos_next   = total_reg;
                        found_next = 1'b0;
                        state_next = S_DECIDE;
                    end else begin
                        idx_next   = idx_reg + ONE;
                        raddr_full = idx_reg + ONE;
                    end
                end else begin
                    pos_next   = idx_reg;
                    found_next = (ram_rdata.key == key_reg);
                    cnt_next   = ram_rdata.count;
                    state_next = S_DECIDE;
                end
            end

            S_DECIDE: begin
                ram_waddr  = pos_reg[AW-1:0];
                state_next = S_RESP;
                if (cmd_reg == CMD_ADD) begin
                    if (found_reg) begin
                        if (cnt_reg == CNT_MAX) begin
                            res_next = '{key: key_reg, count: CNT_MAX, status: ST_SAT,
                                         last: 1'b1};
                        end else begin
                            ram_we    = 1'b1;
                            ram_wdata = '{key: key_reg, count: cnt_reg + 16'd1};
                            res_next  = '{key: key_reg, count: cnt_reg + 16'd1,
                                          status: ST_OK, last: 1'b1};
                        end
                    end else if (total_reg == FULLN) begin
                        res_next = '{key: key_reg, count: '0, status: ST_FULL, last: 1'b1};
                    end else if (total_reg == pos_reg) begin
                        state_next = S_INSERT;
                    end else begin
                        idx_next   = total_reg;
                        raddr_full = total_reg - ONE;
                        state_next = S_SHUP;
                    end
                end else begin
                    if (!found_reg) begin
                        res_next = '{key: key_reg, count: '0, status: ST_NOTFOUND,
                                     last: 1'b1};
                    end else if (cnt_reg > 16'd1) begin
                        ram_we    = 1'b1;
                        ram_wdata = '{key: key_reg, count: cnt_reg - 16'd1};
                        res_next  = '{key: key_reg, count: cnt_reg - 16'd1,
                                      status: ST_OK, last: 1'b1};
                    end else if ((pos_reg + ONE) == total_reg) begin
                        total_next = total_reg - ONE;
                        res_next   = '{key: key_reg, count: '0, status: ST_OK, last: 1'b1};
                    end else begin
                        idx_next   = pos_reg;
                        raddr_full = pos_reg + ONE;
                        state_next = S_SHDN;
                    end
                end
            end

            // move entries up one slot, top first, to open the gap
            S_SHUP: begin
                ram_we = 1'b1;
                if ((idx_reg - ONE) == pos_reg) begin
                    state_next = S_INSERT;
                end else begin
                    idx_next   = idx_reg - ONE;
                    raddr_full = idx_reg - TWO;
                end
            end

            S_INSERT: begin
                ram_we     = 1'b1;
                ram_waddr  = pos_reg[AW-1:0];
                ram_wdata  = '{key: key_reg, count: 16'd1};
                total_next = total_reg + ONE;
                res_next   = '{key: key_reg, count: 16'd1, status: ST_OK, last: 1'b1};
                state_next = S_RESP;
            end

            // move entries down one slot to close the gap
            S_SHDN: begin
                ram_we = 1'b1;
                if ((idx_reg + TWO) < total_reg) begin
                    idx_next   = idx_reg + ONE;
                    raddr_full = idx_reg + TWO;
                end else begin
                    total_next = total_reg - ONE;
                    res_next   = '{key: key_reg, count: '0, status: ST_OK, last: 1'b1};
                    state_next = S_RESP;
                end
            end

            S_RESP: begin
                res_valid = 1'b1;
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end

            // stream the table out, re-reading the same slot while stalled
            S_DUMP: begin
                res_valid = 1'b1;
                res       = '{key: ram_rdata.key, count: ram_rdata.count, status: ST_OK,
                              last: dump_last};
                if (res_ready) begin
                    if (dump_last) begin
                        state_next = S_IDLE;
                    end else begin
                        idx_next   = idx_reg + ONE;
                        raddr_full = idx_reg + ONE;
                    end
                end
            end

            default: state_next = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            total_reg <= '0;
        end else begin
            state_reg <= state_next;
            total_reg <= total_next;
        end
    end

    // working registers
    always_ff @(posedge aclk) begin
        cmd_reg   <= cmd_next;
        key_reg   <= key_next;
        idx_reg   <= idx_next;
        pos_reg   <= pos_next;
        found_reg <= found_next;
        cnt_reg   <= cnt_next;
        res_reg   <= res_next;
    end

endmodule
`default_nettype wire

[design/sorted_counted_multiset_top.sv]
// top level of the sorted counted multiset: ram, sequencer, output register
//
//  channel | dir | tdata (lsb up)                          | tuser        | tlast
//  s_      | in  | key[15:0]                               | command[1:0] | -
//  m_      | out | out_key[15:0] out_count[31:16]         | -            | last
//          |     | status[34:32], zero pad to 40 bits      |              |
//
// add or remove: the sequencer compares each entry read up to the first key not below the
// request (none on an empty table), decides, moves entries, writes a new key when adding
// one, then hands over the result; the single ram read port walks the table one entry a
// cycle. dump: one entry per cycle while the m_ side accepts, or a single ST_EMPTY item
// for an empty table. results are held in the output register that drives m_tvalid.
// s_tready is high only while the sequencer is idle. aresetn empties the table;
// the ram needs no clearing. a stalled m_ side holds the output register and the
// sequencer waits on it.
`default_nettype none
module sorted_counted_multiset_top #(
    parameter int DEPTH = 32
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // key[15:0]
    input  wire logic [1:0]  s_tuser,   // command[1:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata,   // out_key[15:0], out_count[31:16], status[34:32]
    output logic             m_tlast
);
    import scm_pkg::*;

    localparam int AW = $clog2(DEPTH);

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [AW-1:0] ram_raddr;
    entry_t        ram_wdata;
    entry_t        ram_rdata;
    logic          res_valid;
    logic          res_ready;
    res_t          res;
    logic          m_valid_reg;
    res_t          m_res_reg;

    scm_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    scm_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_cmd    (s_tuser),
        .in_key    (s_tdata),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    // output register takes a new item when empty or being drained
    assign res_ready = !m_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_ready) begin
            m_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_ready && res_valid) begin
            m_res_reg <= res;
        end
    end

    // result packing
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {5'b0, m_res_reg.status, m_res_reg.count, m_res_reg.key};
    assign m_tlast  = m_res_reg.last;

endmodule
`default_nettype wire
